// ===== design/dcc_pkg.sv =====
// dcc_pkg: shared types and constants for the door open/close controller
// no dependencies; imported by all but dcc_in_if and dcc_out_if
package dcc_pkg;

    typedef logic [3:0] t_state;

    localparam t_state ST_WATCH       = 4'd0;
    localparam t_state ST_OPEN_PULSE  = 4'd1;
    localparam t_state ST_OPENING     = 4'd2;
    localparam t_state ST_OPEN_ERR    = 4'd3;
    localparam t_state ST_IDLE        = 4'd4;
    localparam t_state ST_WAIT        = 4'd5;
    localparam t_state ST_CLOSE_PULSE = 4'd6;
    localparam t_state ST_CLOSING     = 4'd7;
    localparam t_state ST_CLOSE_ERR   = 4'd8;

    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_TIME      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OPEN_TIME   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELAY_PULSE_TIME = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_ATTEMPTS   = 4'd3;

    localparam logic [7:0] RST_TRAVEL_TIME      = 8'd20;
    localparam logic [7:0] RST_HOLD_OPEN_TIME   = 8'd140;
    localparam logic [3:0] RST_RELAY_PULSE_TIME = 4'd1;
    localparam logic [2:0] RST_CLOSE_ATTEMPTS   = 3'd3;

    typedef struct packed {
        logic [7:0] travel_time;
        logic [7:0] hold_open_time;
        logic [3:0] relay_pulse_time;
        logic [2:0] close_attempts;
    } t_cfg;

    typedef struct packed {
        logic second_tick;
        logic door_sensor;
        logic lockdown;
        logic open_request;
        logic close_request;
    } t_item;

    typedef struct packed {
        t_state     state;
        logic       entry_pending;
        logic [7:0] timer;
        logic [2:0] attempts;
        logic       open_latched;
        logic       close_latched;
        logic       sensor_seen;
        logic       lockdown_seen;
    } t_ctrl;

    typedef struct packed {
        t_state door_state;
        logic   relay_closed;
        logic   report_valid;
        logic   report_door_open;
    } t_result;

endpackage

// ===== design/dcc_in_if.sv =====
// dcc_in_if: request channel carrying one control loop pass
// no dependencies
interface dcc_in_if;
    logic valid;
    logic ready;
    logic second_tick;
    logic door_sensor;
    logic lockdown;
    logic open_request;
    logic close_request;

    modport source (output valid, second_tick, door_sensor, lockdown, open_request,
                    close_request, input ready);
    modport sink   (input valid, second_tick, door_sensor, lockdown, open_request,
                    close_request, output ready);
endinterface

// ===== design/dcc_out_if.sv =====
// dcc_out_if: result channel with door state, relay and status report
// no dependencies
interface dcc_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] door_state;
    logic       relay_closed;
    logic       report_valid;
    logic       report_door_open;

    modport source (output valid, door_state, relay_closed, report_valid,
                    report_door_open, input ready);
    modport sink   (input valid, door_state, relay_closed, report_valid,
                    report_door_open, output ready);
endinterface

// ===== design/dcc_cfg_if.sv =====
// dcc_cfg_if: register write channel
// depends on dcc_pkg for index and data widths
interface dcc_cfg_if
    import dcc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

// ===== design/door_open_close_controller_unit.sv =====
// door_open_close_controller_unit: top level of the door open/close controller
// depends on dcc_pkg, dcc_in_if, dcc_out_if, dcc_cfg_if, dcc_cfg_regs, dcc_step
// a result is registered and becomes valid in the cycle after its request is accepted
// throughput: one request per cycle unless a result stalls; r_ctrl and r_res update together
// a request is taken while a held result waits if the result is taken in the same cycle
// reset: synchronous active low, state to watch with entry actions due, registers to defaults
module door_open_close_controller_unit
    import dcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcc_in_if.sink    i_in,
    dcc_out_if.source o_out,
    dcc_cfg_if.sink   i_cfg
);

    t_cfg    cfg;
    t_item   item;
    t_ctrl   r_ctrl;
    t_ctrl   n_ctrl;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    in_fire;

    dcc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign item.second_tick   = i_in.second_tick;
    assign item.door_sensor   = i_in.door_sensor;
    assign item.lockdown      = i_in.lockdown;
    assign item.open_request  = i_in.open_request;
    assign item.close_request = i_in.close_request;

    dcc_step u_step (
        .i_cur  (r_ctrl),
        .i_cfg  (cfg),
        .i_item (item),
        .o_nxt  (n_ctrl),
        .o_res  (n_res)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.state         <= ST_WATCH;
            r_ctrl.entry_pending <= 1'b1;
            r_ctrl.timer         <= 8'd0;
            r_ctrl.attempts      <= 3'd0;
            r_ctrl.open_latched  <= 1'b0;
            r_ctrl.close_latched <= 1'b0;
            r_ctrl.sensor_seen   <= 1'b0;
            r_ctrl.lockdown_seen <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ctrl <= n_ctrl;
            end
            if (in_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.door_state       = r_res.door_state;
    assign o_out.relay_closed     = r_res.relay_closed;
    assign o_out.report_valid     = r_res.report_valid;
    assign o_out.report_door_open = r_res.report_door_open;

endmodule

// ===== design/dcc_cfg_regs.sv =====
// dcc_cfg_regs: timing and retry configuration registers
// depends on dcc_pkg and dcc_cfg_if
module dcc_cfg_regs
    import dcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dcc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.travel_time      <= RST_TRAVEL_TIME;
            r_cfg.hold_open_time   <= RST_HOLD_OPEN_TIME;
            r_cfg.relay_pulse_time <= RST_RELAY_PULSE_TIME;
            r_cfg.close_attempts   <= RST_CLOSE_ATTEMPTS;
        end else if (i_cfg.valid) begin
            case (i_cfg.idx)
                CFG_TRAVEL_TIME:      r_cfg.travel_time      <= i_cfg.data;
                CFG_HOLD_OPEN_TIME:   r_cfg.hold_open_time   <= i_cfg.data;
                CFG_RELAY_PULSE_TIME: r_cfg.relay_pulse_time <= i_cfg.data[3:0];
                CFG_CLOSE_ATTEMPTS:   r_cfg.close_attempts   <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/dcc_step.sv =====
// dcc_step: next-state and result logic for one control loop pass
// depends on dcc_pkg
module dcc_step
    import dcc_pkg::*;
(
    input  t_ctrl   i_cur,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_ctrl   o_nxt,
    output t_result o_res
);

    t_ctrl  n;
    t_state ns;
    logic   relay;
    logic   rep;
    logic   rep_open;

    always_comb begin
        n        = i_cur;
        ns       = i_cur.state;
        relay    = 1'b0;
        rep      = 1'b0;
        rep_open = 1'b0;

        if (i_item.second_tick && (n.timer != 8'd0)) begin
            n.timer = n.timer - 8'd1;
        end

        case (i_cur.state)
            ST_WATCH: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    rep             = 1'b1;
                    n.open_latched  = 1'b0;
                end
                if (n.open_latched && !i_cur.lockdown_seen) begin
                    ns = ST_OPEN_PULSE;
                end else if (i_cur.sensor_seen) begin
                    ns = ST_WAIT;
                end
            end
            ST_OPEN_PULSE, ST_CLOSE_PULSE: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    n.timer         = {4'd0, i_cfg.relay_pulse_time};
                end
                if (n.timer == 8'd0) begin
                    ns = (i_cur.state == ST_OPEN_PULSE) ? ST_OPENING : ST_CLOSING;
                end else begin
                    relay = 1'b1;
                end
            end
            ST_OPENING: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    n.timer         = i_cfg.travel_time;
                end
                if (n.timer == 8'd0) begin
                    ns = ST_OPEN_ERR;
                end else if (i_cur.sensor_seen) begin
                    ns = ST_IDLE;
                end
            end
            ST_OPEN_ERR: begin
                if (i_cur.sensor_seen) begin
                    ns = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    n.close_latched = 1'b0;
                    n.open_latched  = 1'b0;
                    rep             = 1'b1;
                    rep_open        = 1'b1;
                end
                if (n.close_latched) begin
                    n.attempts = i_cfg.close_attempts;
                    ns         = ST_CLOSE_PULSE;
                end else if (!i_cur.sensor_seen) begin
                    ns = ST_WATCH;
                end
            end
            ST_WAIT: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    n.close_latched = 1'b0;
                    rep             = 1'b1;
                    rep_open        = 1'b1;
                    n.timer         = i_cfg.hold_open_time;
                end
                if (!i_cur.sensor_seen) begin
                    ns = ST_WATCH;
                end else if ((n.timer == 8'd0) || n.close_latched) begin
                    n.attempts = i_cfg.close_attempts;
                    ns         = ST_CLOSE_PULSE;
                end
            end
            ST_CLOSING: begin
                if (i_cur.entry_pending) begin
                    n.entry_pending = 1'b0;
                    n.timer         = i_cfg.travel_time;
                end
                if (!i_cur.sensor_seen) begin
                    ns = ST_WATCH;
                end else if (n.timer == 8'd0) begin
                    if (i_cur.attempts > 3'd1) begin
                        n.attempts = i_cur.attempts - 3'd1;
                        ns         = ST_CLOSE_PULSE;
                    end else begin
                        ns = ST_CLOSE_ERR;
                    end
                end
            end
            ST_CLOSE_ERR: begin
                if (!i_cur.sensor_seen) begin
                    ns = ST_WATCH;
                end
            end
            default: begin
                ns = ST_WATCH;
            end
        endcase

        if (ns != i_cur.state) begin
            n.entry_pending = 1'b1;
        end
        n.state = ns;

        if (i_item.open_request) begin
            n.open_latched = 1'b1;
        end
        if (i_item.close_request) begin
            n.close_latched = 1'b1;
        end
        n.sensor_seen   = i_item.door_sensor;
        n.lockdown_seen = i_item.lockdown;
    end

    assign o_nxt                  = n;
    assign o_res.door_state       = ns;
    assign o_res.relay_closed     = relay;
    assign o_res.report_valid     = rep;
    assign o_res.report_door_open = rep & rep_open;

endmodule

// ===== design/dcc_checker.sv =====
// dcc_checker: port-level assertions for the door open/close controller
// depends on dcc_pkg; bound to door_open_close_controller_unit
module dcc_checker
    import dcc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [3:0] i_door_state,
    input logic       i_relay_closed,
    input logic       i_report_valid,
    input logic       i_report_door_open
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_door_state) && $stable(i_relay_closed) &&
            $stable(i_report_valid) && $stable(i_report_door_open))
        else $error("result changed while stalled");

    // no new request while a result is stuck
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("request taken over a stalled result");

    // relay only closes during a pulse state
    a_relay_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_relay_closed |->
            (i_door_state == ST_OPEN_PULSE) || (i_door_state == ST_CLOSE_PULSE))
        else $error("relay closed outside a pulse state");

    // open report only with a report
    a_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_report_door_open |-> i_report_valid)
        else $error("open status without report");

    // accepted request yields a result next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid && (i_door_state <= ST_CLOSE_ERR))
        else $error("missing or bad result after request");

endmodule

bind door_open_close_controller_unit dcc_checker u_dcc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_door_state       (o_out.door_state),
    .i_relay_closed     (o_out.relay_closed),
    .i_report_valid     (o_out.report_valid),
    .i_report_door_open (o_out.report_door_open)
);
